// ----- design/clif_pkg.sv -----
// -----------------------------------------------------------------------------
// clif_pkg
// Types, register codes and reset constants shared by the conductance LIF
// neuron step block.
// -----------------------------------------------------------------------------
package clif_pkg;

  // Request actions and synapse kinds
  localparam logic ACT_EVENT  = 1'b0;
  localparam logic ACT_TICK   = 1'b1;
  localparam logic KIND_EXCIT = 1'b0;
  localparam logic KIND_INHIB = 1'b1;

  // Register indexes (byte address = 4 * index)
  localparam int unsigned    REG_IDX_W        = 3;
  localparam int unsigned    ADDR_W           = 5;
  localparam logic [2:0]     REG_EXCIT_REV    = 3'd0;
  localparam logic [2:0]     REG_INHIB_REV    = 3'd1;
  localparam logic [2:0]     REG_REST_POT     = 3'd2;
  localparam logic [2:0]     REG_FIRE_THRESH  = 3'd3;
  localparam logic [2:0]     REG_LEAK_RATE    = 3'd4;
  localparam logic [2:0]     REG_EXCIT_DECAY  = 3'd5;
  localparam logic [2:0]     REG_INHIB_DECAY  = 3'd6;
  localparam logic [2:0]     REG_REFRACT      = 3'd7;

  // Reset values, Q4.28 volts
  localparam logic signed [31:0] EXCIT_REV_RST   = 32'sd0;
  localparam logic signed [31:0] INHIB_REV_RST   = -32'sd21474836;
  localparam logic signed [31:0] REST_POT_RST    = -32'sd18790482;
  localparam logic signed [31:0] FIRE_THRESH_RST = -32'sd14495514;

  localparam logic [15:0] STEPS_MAX = 16'hFFFF;
  localparam logic [31:0] COND_MAX  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        action;
    logic        synapse_kind;
    logic [15:0] weight;
  } in_item_t;

  typedef struct packed {
    logic               fired;
    logic signed [31:0] membrane_out;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] excit_reversal;
    logic signed [31:0] inhib_reversal;
    logic signed [31:0] rest_potential;
    logic signed [31:0] fire_threshold;
    logic [15:0]        leak_rate;
    logic [15:0]        excit_decay;
    logic [15:0]        inhib_decay;
    logic [15:0]        refractory_steps;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] membrane_voltage;
    logic [31:0]        excit_conductance;
    logic [31:0]        inhib_conductance;
    logic [15:0]        steps_since_spike;
  } nrn_state_t;

endpackage

// ----- design/clif_cfg_regs.sv -----
// -----------------------------------------------------------------------------
// clif_cfg_regs
// APB-style register file holding the neuron parameters.
// -----------------------------------------------------------------------------
module clif_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [clif_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output clif_pkg::cfg_t              cfg
);
  import clif_pkg::*;

  cfg_t                 cfg_r;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.excit_reversal   <= EXCIT_REV_RST;
      cfg_r.inhib_reversal   <= INHIB_REV_RST;
      cfg_r.rest_potential   <= REST_POT_RST;
      cfg_r.fire_threshold   <= FIRE_THRESH_RST;
      cfg_r.leak_rate        <= 16'd0;
      cfg_r.excit_decay      <= 16'd0;
      cfg_r.inhib_decay      <= 16'd0;
      cfg_r.refractory_steps <= 16'd0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_EXCIT_REV:   cfg_r.excit_reversal   <= pwdata;
        REG_INHIB_REV:   cfg_r.inhib_reversal   <= pwdata;
        REG_REST_POT:    cfg_r.rest_potential   <= pwdata;
        REG_FIRE_THRESH: cfg_r.fire_threshold   <= pwdata;
        REG_LEAK_RATE:   cfg_r.leak_rate        <= pwdata[15:0];
        REG_EXCIT_DECAY: cfg_r.excit_decay      <= pwdata[15:0];
        REG_INHIB_DECAY: cfg_r.inhib_decay      <= pwdata[15:0];
        REG_REFRACT:     cfg_r.refractory_steps <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_EXCIT_REV:   prdata = cfg_r.excit_reversal;
      REG_INHIB_REV:   prdata = cfg_r.inhib_reversal;
      REG_REST_POT:    prdata = cfg_r.rest_potential;
      REG_FIRE_THRESH: prdata = cfg_r.fire_threshold;
      REG_LEAK_RATE:   prdata = {16'd0, cfg_r.leak_rate};
      REG_EXCIT_DECAY: prdata = {16'd0, cfg_r.excit_decay};
      REG_INHIB_DECAY: prdata = {16'd0, cfg_r.inhib_decay};
      REG_REFRACT:     prdata = {16'd0, cfg_r.refractory_steps};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

// ----- design/clif_update.sv -----
// -----------------------------------------------------------------------------
// clif_update
// Combinational neuron update: synaptic conductance add or one Euler tick
// with firing, reset and conductance decay.
// -----------------------------------------------------------------------------
module clif_update (
  input  clif_pkg::in_item_t   item,
  input  clif_pkg::cfg_t       cfg,
  input  clif_pkg::nrn_state_t st,
  output clif_pkg::nrn_state_t st_nxt,
  output clif_pkg::out_item_t  res
);
  import clif_pkg::*;

  logic [31:0]        g_sel;
  logic [32:0]        g_sum;
  logic [31:0]        g_add;
  logic [15:0]        steps_inc;
  logic               integrate;
  logic signed [32:0] de, di, dl;
  logic signed [49:0] pe_hi, pe_lo, pi_hi, pi_lo, p_leak;
  logic signed [65:0] pe, pi;
  logic signed [39:0] te, ti, tl, v_sum;
  logic signed [31:0] v_sat;
  logic [47:0]        dec_e, dec_i;

  // Saturating conductance add, weight aligned from Q0.16 to Q2.30
  assign g_sel = (item.synapse_kind == KIND_EXCIT) ? st.excit_conductance
                                                   : st.inhib_conductance;
  assign g_sum = {1'b0, g_sel} + (33'(item.weight) << 14);
  assign g_add = g_sum[32] ? COND_MAX : g_sum[31:0];

  assign steps_inc = (st.steps_since_spike != STEPS_MAX) ? st.steps_since_spike + 16'd1
                                                         : st.steps_since_spike;
  assign integrate = steps_inc > cfg.refractory_steps;

  // Driving forces
  assign de = 33'(cfg.excit_reversal) - 33'(st.membrane_voltage);
  assign di = 33'(cfg.inhib_reversal) - 33'(st.membrane_voltage);
  assign dl = 33'(cfg.rest_potential) - 33'(st.membrane_voltage);

  // Conductance products split into 16-bit halves of g
  assign pe_hi  = de * $signed({1'b0, st.excit_conductance[31:16]});
  assign pe_lo  = de * $signed({1'b0, st.excit_conductance[15:0]});
  assign pi_hi  = di * $signed({1'b0, st.inhib_conductance[31:16]});
  assign pi_lo  = di * $signed({1'b0, st.inhib_conductance[15:0]});
  assign p_leak = dl * $signed({1'b0, cfg.leak_rate});

  assign pe = (66'(pe_hi) <<< 16) + 66'(pe_lo);
  assign pi = (66'(pi_hi) <<< 16) + 66'(pi_lo);

  // Arithmetic shifts round toward minus infinity
  assign te = 40'(pe >>> 30);
  assign ti = 40'(pi >>> 30);
  assign tl = 40'(p_leak >>> 16);

  assign v_sum = 40'(st.membrane_voltage) + te + ti + tl;

  always_comb begin
    priority if (v_sum > 40'sh00_7FFF_FFFF) begin
      v_sat = 32'sh7FFF_FFFF;
    end else if (v_sum < -40'sh00_8000_0000) begin
      v_sat = -32'sh8000_0000;
    end else begin
      v_sat = v_sum[31:0];
    end
  end

  assign dec_e = st.excit_conductance * cfg.excit_decay;
  assign dec_i = st.inhib_conductance * cfg.inhib_decay;

  always_comb begin
    st_nxt    = st;
    res.fired = 1'b0;
    if (item.action == ACT_EVENT) begin
      if (item.synapse_kind == KIND_EXCIT) begin
        st_nxt.excit_conductance = g_add;
      end else begin
        st_nxt.inhib_conductance = g_add;
      end
    end else begin
      st_nxt.steps_since_spike = steps_inc;
      if (integrate) begin
        if (v_sat > cfg.fire_threshold) begin
          res.fired                = 1'b1;
          st_nxt.membrane_voltage  = cfg.rest_potential;
          st_nxt.steps_since_spike = 16'd0;
        end else begin
          st_nxt.membrane_voltage = v_sat;
        end
      end
      st_nxt.excit_conductance = dec_e[47:16];
      st_nxt.inhib_conductance = dec_i[47:16];
    end
    res.membrane_out = st_nxt.membrane_voltage;
  end

endmodule

// ----- design/conductance_lif_neuron_step.sv -----
// One conductance-based LIF neuron. Each request (a synaptic event or a time-step
// tick) is taken into an input register; once the result register can advance,
// the neuron state and the result register are updated together from it. A new
// request can be taken every cycle while the result register is not stalled. This
// rate is set by the state loop: the Euler step, firing check and conductance
// decay are combinational from the state registers back to themselves. Registers
// must be written over the APB port only while the block holds no request in
// flight; the block itself does not enforce this.
// -----------------------------------------------------------------------------
// conductance_lif_neuron_step
// Top level: request register, neuron state, result register and APB
// register file.
// -----------------------------------------------------------------------------
module conductance_lif_neuron_step (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  clif_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output clif_pkg::out_item_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [clif_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import clif_pkg::*;

  cfg_t       cfg;
  in_item_t   item_r;
  logic       item_valid_r;
  nrn_state_t st_r, st_nxt;
  out_item_t  res_nxt, res_r;
  logic       out_valid_r;
  logic       advance;

  clif_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  clif_update u_update (
    .item   (item_r),
    .cfg    (cfg),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // Result register frees up when empty or being taken
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = item_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (!in_stall) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.membrane_voltage  <= REST_POT_RST;
      st_r.excit_conductance <= 32'd0;
      st_r.inhib_conductance <= 32'd0;
      st_r.steps_since_spike <= STEPS_MAX;
    end else if (item_valid_r && advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid_r && advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

endmodule

// ----- design/clif_checker.sv -----
// -----------------------------------------------------------------------------
// clif_checker
// Port-level checks for the conductance LIF neuron step block.
// -----------------------------------------------------------------------------
module clif_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input clif_pkg::in_item_t          in_data,
  input logic                        out_valid,
  input logic                        out_stall,
  input clif_pkg::out_item_t         out_data,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [clif_pkg::ADDR_W-1:0] paddr,
  input logic [31:0]                 pwdata,
  input logic [31:0]                 prdata,
  input logic                        pready
);
  import clif_pkg::*;

  logic signed [31:0] rest_r;

  // Track the rest potential written over the bus
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r <= REST_POT_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr[ADDR_W-1:2] == REG_REST_POT) begin
      rest_r <= pwdata;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_fire_rest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fired |-> out_data.membrane_out == rest_r)
    else $error("spike without reset to rest potential");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result register can advance");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  a_prdata_known: assert property (@(posedge clk) disable iff (!rst_n)
    psel && !pwrite |-> !$isunknown(prdata))
    else $error("register read returned unknown data");

endmodule

bind conductance_lif_neuron_step clif_checker u_clif_checker (.*);
